[rtl/max_tracking_fifo_defines.svh]
// ---------------------------------------------------------------------------
// max_tracking_fifo assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MAX_TRACKING_FIFO_DEFINES_SVH
`define MAX_TRACKING_FIFO_DEFINES_SVH

`ifndef SYNTH
`define MTF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mtf: assertion failed");
`define MTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtf: assertion failed");
`else
`define MTF_ASSERT(label, clk, rst, prop)
`define MTF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/mtf_pkg.sv]
// ---------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the max tracking FIFO.
// ---------------------------------------------------------------------------
package mtf_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;   // command queue between front and back

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_CMP,
      ST_POP_DATA
   } back_state_type;

   typedef struct packed {
      logic valid;
      logic is_push;
   } item_ctl_type;

endpackage

[rtl/mtf_ram.sv]
// ---------------------------------------------------------------------------
// mtf_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mtf_front.sv]
// ---------------------------------------------------------------------------
// mtf_front
// Accepts command words, tags them push or pop and queues them for the back.
// ---------------------------------------------------------------------------
`include "max_tracking_fifo_defines.svh"

module mtf_front import mtf_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         req_command,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         busy,
   output item_ctl_type                 item_ctl,
   output logic signed [DATA_WIDTH-1:0] item_value,
   input  logic                         take
);

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                         is_push_ff [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] value_ff   [QUEUE_DEPTH];
   logic [QPTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]            count_ff, count_in;
   logic                         accept;

   function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign busy   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      wr_ptr_in = accept ? qptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = take ? qptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (take && !accept) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_push_ff[wr_ptr_ff] <= (req_command == CMD_PUSH);
         value_ff[wr_ptr_ff]   <= req_value;
      end
   end

   assign item_ctl.valid   = (count_ff != '0);
   assign item_ctl.is_push = is_push_ff[rd_ptr_ff];
   assign item_value       = value_ff[rd_ptr_ff];

   `MTF_ASSERT(a_take_nonempty, clock, reset, !take || (count_ff != '0))
   `MTF_ASSERT_NEXT(a_accept_queued, clock, reset, accept && !take, count_ff != '0)

endmodule

[rtl/mtf_back.sv]
// ---------------------------------------------------------------------------
// mtf_back
// Executes queued push/pop words against the FIFO ring and the max deque.
// ---------------------------------------------------------------------------
`include "max_tracking_fifo_defines.svh"

module mtf_back import mtf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  item_ctl_type                 item_ctl,
   input  logic signed [DATA_WIDTH-1:0] item_value,
   output logic                         take,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_popped_value,
   output logic                         rsp_pop_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_max_value,
   output logic                         rsp_max_valid,
   output logic                         rsp_overflow
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   back_state_type state_ff, state_in;

   logic [PTR_W-1:0] fifo_head_ff, fifo_head_in;
   logic [PTR_W-1:0] fifo_tail_ff, fifo_tail_in;
   logic [CNT_W-1:0] fifo_count_ff, fifo_count_in;
   logic [PTR_W-1:0] max_head_ff, max_head_in;
   logic [PTR_W-1:0] max_tail_ff, max_tail_in;
   logic [CNT_W-1:0] max_count_ff, max_count_in;

   // deque front value, mirrors u_max_ram[max_head] while the deque is not empty
   logic signed [DATA_WIDTH-1:0] front_ff, front_in;
   logic signed [DATA_WIDTH-1:0] val_ff, val_in;

   logic                         strobe_ff, strobe_in;
   logic signed [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic                         pop_valid_ff, pop_valid_in;
   logic signed [DATA_WIDTH-1:0] maxv_ff, maxv_in;
   logic                         max_valid_ff, max_valid_in;
   logic                         overflow_ff, overflow_in;

   logic                         commit;
   logic signed [DATA_WIDTH-1:0] commit_val;
   logic [PTR_W-1:0]             commit_tail;
   logic [CNT_W-1:0]             commit_count;

   logic                         fifo_we;
   logic signed [DATA_WIDTH-1:0] fifo_rdata;
   logic                         max_we;
   logic [PTR_W-1:0]             max_raddr;
   logic signed [DATA_WIDTH-1:0] max_rdata;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

   mtf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_tail_ff),
      .wr_data (commit_val),
      .rd_addr (fifo_head_ff),
      .rd_data (fifo_rdata)
   );

   mtf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_max_ram (
      .clock   (clock),
      .wr_en   (max_we),
      .wr_addr (commit_tail),
      .wr_data (commit_val),
      .rd_addr (max_raddr),
      .rd_data (max_rdata)
   );

   always_comb begin
      logic [CNT_W-1:0] mc_n;
      logic [CNT_W-1:0] fc_n;
      logic [PTR_W-1:0] tail_n;
      logic             front_hit;

      state_in      = state_ff;
      fifo_head_in  = fifo_head_ff;
      fifo_tail_in  = fifo_tail_ff;
      fifo_count_in = fifo_count_ff;
      max_head_in   = max_head_ff;
      max_tail_in   = max_tail_ff;
      max_count_in  = max_count_ff;
      front_in      = front_ff;
      val_in        = val_ff;
      take          = 1'b0;
      commit        = 1'b0;
      commit_val    = val_ff;
      commit_tail   = max_tail_ff;
      commit_count  = max_count_ff;
      max_raddr     = ptr_prev(max_tail_ff);
      strobe_in     = 1'b0;
      popped_in     = '0;
      pop_valid_in  = 1'b0;
      overflow_in   = 1'b0;
      max_valid_in  = (fifo_count_ff != '0) && (max_count_ff != '0);
      maxv_in       = max_valid_in ? front_ff : '0;
      mc_n          = max_count_ff;
      fc_n          = fifo_count_ff;
      tail_n        = max_tail_ff;
      front_hit     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_ctl.valid) begin
               take   = 1'b1;
               val_in = item_value;
               if (item_ctl.is_push) begin
                  if (fifo_count_ff == CNT_W'(DEPTH)) begin
                     strobe_in   = 1'b1;
                     overflow_in = 1'b1;
                  end else if (max_count_ff == '0) begin
                     commit     = 1'b1;
                     commit_val = item_value;
                  end else begin
                     state_in = ST_PUSH_CMP;
                  end
               end else begin
                  if (fifo_count_ff == '0) begin
                     strobe_in = 1'b1;
                  end else begin
                     // prefetch the entry behind the deque front
                     max_raddr = ptr_next(max_head_ff);
                     state_in  = ST_POP_DATA;
                  end
               end
            end
         end
         ST_PUSH_CMP: begin
            if (max_rdata < val_ff) begin
               tail_n = ptr_prev(max_tail_ff);
               mc_n   = max_count_ff - CNT_W'(1);
               if (mc_n == '0) begin
                  commit       = 1'b1;
                  commit_tail  = tail_n;
                  commit_count = mc_n;
               end else begin
                  max_tail_in  = tail_n;
                  max_count_in = mc_n;
                  max_raddr    = ptr_prev(tail_n);
               end
            end else begin
               commit = 1'b1;
            end
         end
         ST_POP_DATA: begin
            fc_n          = fifo_count_ff - CNT_W'(1);
            fifo_head_in  = ptr_next(fifo_head_ff);
            fifo_count_in = fc_n;
            front_hit     = (max_count_ff != '0) && (front_ff == fifo_rdata);
            if (front_hit) begin
               mc_n         = max_count_ff - CNT_W'(1);
               max_head_in  = ptr_next(max_head_ff);
               max_count_in = mc_n;
               front_in     = max_rdata;
            end
            strobe_in    = 1'b1;
            popped_in    = fifo_rdata;
            pop_valid_in = 1'b1;
            max_valid_in = (fc_n != '0) && (mc_n != '0);
            maxv_in      = max_valid_in ? (front_hit ? max_rdata : front_ff) : '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // push lands in both rings; deque keeps entries not below the new value
      if (commit) begin
         max_tail_in   = ptr_next(commit_tail);
         max_count_in  = commit_count + CNT_W'(1);
         fifo_tail_in  = ptr_next(fifo_tail_ff);
         fifo_count_in = fifo_count_ff + CNT_W'(1);
         if (commit_count == '0) begin
            front_in = commit_val;
         end
         strobe_in    = 1'b1;
         max_valid_in = 1'b1;
         maxv_in      = (commit_count == '0) ? commit_val : front_ff;
         state_in     = ST_IDLE;
      end
   end

   assign fifo_we = commit;
   assign max_we  = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fifo_head_ff  <= '0;
         fifo_tail_ff  <= '0;
         fifo_count_ff <= '0;
         max_head_ff   <= '0;
         max_tail_ff   <= '0;
         max_count_ff  <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_tail_ff  <= fifo_tail_in;
         fifo_count_ff <= fifo_count_in;
         max_head_ff   <= max_head_in;
         max_tail_ff   <= max_tail_in;
         max_count_ff  <= max_count_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      val_ff       <= val_in;
      popped_ff    <= popped_in;
      pop_valid_ff <= pop_valid_in;
      maxv_ff      <= maxv_in;
      max_valid_ff <= max_valid_in;
      overflow_ff  <= overflow_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_pop_valid    = pop_valid_ff;
   assign rsp_max_value    = maxv_ff;
   assign rsp_max_valid    = max_valid_ff;
   assign rsp_overflow     = overflow_ff;

   `MTF_ASSERT(a_deque_within_fifo, clock, reset, max_count_ff <= fifo_count_ff)
   `MTF_ASSERT(a_walk_nonempty, clock, reset, (state_ff != ST_PUSH_CMP) || (max_count_ff != '0))
   `MTF_ASSERT_NEXT(a_pop_reports, clock, reset, state_ff == ST_POP_DATA, strobe_ff && pop_valid_ff)

endmodule

[rtl/max_tracking_fifo.sv]
// ---------------------------------------------------------------------------
// max_tracking_fifo
// FIFO of signed words that reports the largest word it currently holds.
// ---------------------------------------------------------------------------
//
//  channel  | handshake          | ports
//  ---------+--------------------+---------------------------------------------
//  request  | start & !busy      | req_command, req_value
//  response | rsp_strobe, 1 cyc  | rsp_popped_value, rsp_pop_valid,
//           |                    | rsp_max_value, rsp_max_valid, rsp_overflow
//
//  Steps: a pop runs in the back as ST_IDLE then ST_POP_DATA (one RAM read of
//  FIFO head and the word behind the deque front); a push runs ST_IDLE then
//  ST_PUSH_CMP, which walks the deque from its tail removing one entry per
//  cycle, and commits in the step that stops the walk or empties the deque.
//  Pop from empty, dropped push and push into an empty deque finish in ST_IDLE.
//  The response is registered after the back finishes; the 2-entry command
//  queue registers each word on accept. No clearing pass: reset clears
//  pointers, counts, state and strobe only. busy rises when the command queue
//  is full; responses cannot be stalled.
//
module max_tracking_fifo import mtf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_popped_value,
   output logic                         rsp_pop_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_max_value,
   output logic                         rsp_max_valid,
   output logic                         rsp_overflow
);

   item_ctl_type                 item_ctl;
   logic signed [DATA_WIDTH-1:0] item_value;
   logic                         take;

   mtf_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .req_value   (req_value),
      .busy        (busy),
      .item_ctl    (item_ctl),
      .item_value  (item_value),
      .take        (take)
   );

   mtf_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_ctl         (item_ctl),
      .item_value       (item_value),
      .take             (take),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_pop_valid    (rsp_pop_valid),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_valid    (rsp_max_valid),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
